// File: sv/tovn_pkg.sv
// Shared constants for the two-octave value noise pipeline.
package tovn_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned CELL_W        = 6;   // cell index incl. +1 neighbor, max 33
    localparam int unsigned HASH_W        = 32;
    localparam int unsigned VAL_W         = 16;
    localparam int unsigned NUM_STAGES    = 8;

    localparam logic [HASH_W-1:0] HASH_K1 = 32'h9E3779B1;
    localparam logic [HASH_W-1:0] HASH_K2 = 32'h85EBCA77;
    localparam logic [HASH_W-1:0] HASH_K3 = 32'h2C1B3C6D;
    localparam logic [HASH_W-1:0] HASH_K4 = 32'h297A2D39;

    localparam int unsigned HASH_SHIFT_A = 15;
    localparam int unsigned HASH_SHIFT_B = 12;
    localparam int unsigned HASH_SHIFT_C = 15;

    // Octave scales and offsets in whole cells
    localparam int unsigned OCT1_SCALE = 5;
    localparam int unsigned OCT2_SCALE = 13;
    localparam int unsigned OCT2_OFF_U = 7;
    localparam int unsigned OCT2_OFF_V = 3;

    // Octave weights in Q0.16, truncated
    localparam logic [VAL_W-1:0] W_LOW  = 16'd44564;
    localparam logic [VAL_W-1:0] W_HIGH = 16'd20971;

endpackage

// File: sv/tovn_hash.sv
// Four-stage pipelined multiply-xorshift corner hash.
module tovn_hash
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [tovn_pkg::CELL_W-1:0]  cell_x,
    input  logic [tovn_pkg::CELL_W-1:0]  cell_y,
    output logic [tovn_pkg::VAL_W-1:0]   corner
);

    localparam int unsigned HW = tovn_pkg::HASH_W;

    logic [HW-1:0]               mix_a;
    logic [HW-1:0]               h1_next;
    logic [HW-1:0]               h1_reg;
    logic [HW-1:0]               h2_next;
    logic [HW-1:0]               h2_reg;
    logic [HW-1:0]               xs_b;
    logic [HW-1:0]               h3_next;
    logic [HW-1:0]               h3_reg;
    logic [HW-1:0]               xs_c;
    logic [tovn_pkg::VAL_W-1:0]  corner_next;
    logic [tovn_pkg::VAL_W-1:0]  corner_reg;

    always_comb
    begin
        mix_a       = (HW'(cell_x) * tovn_pkg::HASH_K1) ^ (HW'(cell_y) * tovn_pkg::HASH_K2);
        h1_next     = mix_a ^ (mix_a >> tovn_pkg::HASH_SHIFT_A);
        h2_next     = h1_reg * tovn_pkg::HASH_K3;
        xs_b        = h2_reg ^ (h2_reg >> tovn_pkg::HASH_SHIFT_B);
        h3_next     = xs_b * tovn_pkg::HASH_K4;
        xs_c        = h3_reg ^ (h3_reg >> tovn_pkg::HASH_SHIFT_C);
        corner_next = xs_c[HW-1 -: tovn_pkg::VAL_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg     <= h1_next;
            h2_reg     <= h2_next;
            h3_reg     <= h3_next;
            corner_reg <= corner_next;
        end
    end

    assign corner = corner_reg;

endmodule

// File: sv/tovn_fade.sv
// Two-stage smoothstep fade of a cell fraction.
module tovn_fade
#(
    parameter int unsigned FRAC_BITS = tovn_pkg::FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [FRAC_BITS-1:0]  frac,
    output logic [FRAC_BITS:0]    fade
);

    localparam int unsigned SQ_W = 2 * FRAC_BITS;
    localparam int unsigned K_W  = FRAC_BITS + 2;
    localparam int unsigned P_W  = 2 * FRAC_BITS + 2;

    logic [SQ_W-1:0]      sq;
    logic [FRAC_BITS-1:0] t2_next;
    logic [FRAC_BITS-1:0] t2_reg;
    logic [K_W-1:0]       k_next;
    logic [K_W-1:0]       k_reg;
    logic [P_W-1:0]       prod;
    logic [FRAC_BITS:0]   fade_next;
    logic [FRAC_BITS:0]   fade_reg;

    always_comb
    begin
        sq        = SQ_W'(frac) * SQ_W'(frac);
        t2_next   = sq[SQ_W-1:FRAC_BITS];
        k_next    = (K_W'(3) << FRAC_BITS) - K_W'({frac, 1'b0});
        prod      = P_W'(t2_reg) * P_W'(k_reg);
        fade_next = prod[2*FRAC_BITS:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_reg   <= t2_next;
            k_reg    <= k_next;
            fade_reg <= fade_next;
        end
    end

    assign fade = fade_reg;

endmodule

// File: sv/tovn_lerp.sv
// Registered linear blend p + ((q - p) * s) >> F.
module tovn_lerp
#(
    parameter int unsigned FRAC_BITS = tovn_pkg::FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [tovn_pkg::VAL_W-1:0]   p,
    input  logic [tovn_pkg::VAL_W-1:0]   q,
    input  logic [FRAC_BITS:0]           s,
    output logic [tovn_pkg::VAL_W-1:0]   r
);

    localparam int unsigned D_W = tovn_pkg::VAL_W + 1;
    localparam int unsigned PW  = D_W + FRAC_BITS + 2;

    logic signed [D_W-1:0]        diff;
    logic signed [FRAC_BITS+1:0]  s_sgn;
    logic signed [PW-1:0]         prod;
    logic signed [PW-1:0]         sum;
    logic [tovn_pkg::VAL_W-1:0]   r_next;
    logic [tovn_pkg::VAL_W-1:0]   r_reg;

    always_comb
    begin
        diff   = $signed({1'b0, q}) - $signed({1'b0, p});
        s_sgn  = $signed({1'b0, s});
        prod   = PW'(diff) * PW'(s_sgn);
        // the arithmetic shift floors the signed scaled difference
        sum    = PW'($signed({1'b0, p})) + (prod >>> FRAC_BITS);
        r_next = sum[tovn_pkg::VAL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
        end
    end

    assign r = r_reg;

endmodule

// File: sv/two_octave_value_noise.sv
// Top level: two-octave value noise, eight-stage pipeline with stream ports.
// Throughput: one request per cycle while the output is not stalled;
// the 32x32 hash multipliers set the stage depth.
// A stall at the output holds every stage in place; s_tready drops only then.
// Reset clears the stage valid bits only; data registers are not reset.
module two_octave_value_noise
#(
    parameter int unsigned FRAC_BITS = tovn_pkg::FRAC_BITS_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // coord_u [FRAC_BITS:0], coord_v next, zero fill to whole bytes
    input  logic [((2*(FRAC_BITS+1)+7)/8)*8-1:0]      s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // noise_value [15:0]
    output logic [tovn_pkg::VAL_W-1:0]                m_tdata
);

    localparam int unsigned IN_W  = FRAC_BITS + 1;
    localparam int unsigned XW    = FRAC_BITS + tovn_pkg::CELL_W;
    localparam int unsigned CW    = tovn_pkg::CELL_W;
    localparam int unsigned VW    = tovn_pkg::VAL_W;
    localparam int unsigned NSTG  = tovn_pkg::NUM_STAGES;
    localparam int unsigned SUM_W = 2 * VW + 1;

    // Global advance: every stage moves when the output slot is free or taken.
    logic            en;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    logic [IN_W-1:0] coord_u;
    logic [IN_W-1:0] coord_v;

    // Stage 1: scaled coordinates split into cell and fraction, per octave
    logic [XW-1:0]        xs [2];
    logic [XW-1:0]        ys [2];
    logic [CW-1:0]        cell_x_reg [2];
    logic [CW-1:0]        cell_y_reg [2];
    logic [FRAC_BITS-1:0] frac_x_reg [2];
    logic [FRAC_BITS-1:0] frac_y_reg [2];

    // Stages 3-6: fade outputs and their alignment delays
    logic [FRAC_BITS:0]   sx   [2];
    logic [FRAC_BITS:0]   sy   [2];
    logic [FRAC_BITS:0]   sx4_reg [2];
    logic [FRAC_BITS:0]   sx5_reg [2];
    logic [FRAC_BITS:0]   sy4_reg [2];
    logic [FRAC_BITS:0]   sy5_reg [2];
    logic [FRAC_BITS:0]   sy6_reg [2];

    // Corner values (a, b, c, d) per octave, valid at stage 5
    logic [VW-1:0]        corner [2][4];
    // Stage 6 row blends, stage 7 octave values
    logic [VW-1:0]        row_lo [2];
    logic [VW-1:0]        row_hi [2];
    logic [VW-1:0]        oct_val [2];

    // Stage 8: weighted sum and saturation
    logic [SUM_W-1:0]     wsum;
    logic [VW:0]          wscaled;
    logic [VW-1:0]        noise_next;
    logic [VW-1:0]        noise_reg;

    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = noise_reg;

    assign coord_u = s_tdata[IN_W-1:0];
    assign coord_v = s_tdata[2*IN_W-1:IN_W];

    assign vld_next = {vld_reg[NSTG-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Octave 1 at five times the coordinate, octave 2 at thirteen times plus offset
    always_comb
    begin
        xs[0] = XW'(coord_u) * XW'(tovn_pkg::OCT1_SCALE);
        ys[0] = XW'(coord_v) * XW'(tovn_pkg::OCT1_SCALE);
        xs[1] = XW'(coord_u) * XW'(tovn_pkg::OCT2_SCALE)
              + (XW'(tovn_pkg::OCT2_OFF_U) << FRAC_BITS);
        ys[1] = XW'(coord_v) * XW'(tovn_pkg::OCT2_SCALE)
              + (XW'(tovn_pkg::OCT2_OFF_V) << FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int o = 0; o < 2; o++)
            begin
                cell_x_reg[o] <= xs[o][XW-1:FRAC_BITS];
                cell_y_reg[o] <= ys[o][XW-1:FRAC_BITS];
                frac_x_reg[o] <= xs[o][FRAC_BITS-1:0];
                frac_y_reg[o] <= ys[o][FRAC_BITS-1:0];
                // align fades with the corner hashes and the row blends
                sx4_reg[o]    <= sx[o];
                sx5_reg[o]    <= sx4_reg[o];
                sy4_reg[o]    <= sy[o];
                sy5_reg[o]    <= sy4_reg[o];
                sy6_reg[o]    <= sy5_reg[o];
            end
        end
    end

    for (genvar o = 0; o < 2; o++)
    begin : g_oct
        tovn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x
        (
            .clk  (clk),
            .en   (en),
            .frac (frac_x_reg[o]),
            .fade (sx[o])
        );

        tovn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y
        (
            .clk  (clk),
            .en   (en),
            .frac (frac_y_reg[o]),
            .fade (sy[o])
        );

        // corner bit 0 steps x, bit 1 steps y; cells never reach the top of CW bits
        for (genvar c = 0; c < 4; c++)
        begin : g_corner
            tovn_hash u_hash
            (
                .clk    (clk),
                .en     (en),
                .cell_x (cell_x_reg[o] + CW'(c % 2)),
                .cell_y (cell_y_reg[o] + CW'(c / 2)),
                .corner (corner[o][c])
            );
        end

        tovn_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_lo
        (
            .clk (clk),
            .en  (en),
            .p   (corner[o][0]),
            .q   (corner[o][1]),
            .s   (sx5_reg[o]),
            .r   (row_lo[o])
        );

        tovn_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_hi
        (
            .clk (clk),
            .en  (en),
            .p   (corner[o][2]),
            .q   (corner[o][3]),
            .s   (sx5_reg[o]),
            .r   (row_hi[o])
        );

        tovn_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_y
        (
            .clk (clk),
            .en  (en),
            .p   (row_lo[o]),
            .q   (row_hi[o]),
            .s   (sy6_reg[o]),
            .r   (oct_val[o])
        );
    end

    // Weight the octaves, drop 16 fraction bits, clamp to full scale
    always_comb
    begin
        wsum       = SUM_W'(oct_val[0]) * SUM_W'(tovn_pkg::W_LOW)
                   + SUM_W'(oct_val[1]) * SUM_W'(tovn_pkg::W_HIGH);
        wscaled    = wsum[SUM_W-1:VW];
        noise_next = wscaled[VW] ? {VW{1'b1}} : wscaled[VW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            noise_reg <= noise_next;
        end
    end

endmodule

// File: sv/tovn_checker.sv
// Port-level checker for the noise pipeline, bound to the top level.
module tovn_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [tovn_pkg::VAL_W-1:0]  m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // input side blocks only while a result waits at the output
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output slot");

    // with no stall, an accepted request comes out of the last stage as m_tvalid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind two_octave_value_noise tovn_checker u_tovn_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
